/* rtl/rrc_pkg.sv */
// Shared register indexes and curve codes for the range remap unit.
package rrc_pkg;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INPUT_LOW    = 3'd0,
		REG_INPUT_HIGH   = 3'd1,
		REG_OUTPUT_LOW   = 3'd2,
		REG_OUTPUT_HIGH  = 3'd3,
		REG_CURVE_MODE   = 3'd4,
		REG_CLAMP_ENABLE = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		CURVE_LINEAR = 2'd0,
		CURVE_SMOOTH = 2'd1,
		CURVE_SQUARE = 2'd2,
		CURVE_SQRT   = 2'd3
	} curve_t;

endpackage

/* rtl/range_remap_with_curve_unit.sv */
// Range remap with shaping curve: pipelined divide, curve, sqrt and output scale.
//
//  channel  dir  handshake         payload
//  s_*      in   tvalid / tready   tdata: sample_value
//  m_*      out  tvalid / tready   tdata: mapped_value; tuser: saturated, domain_error
//  cfg_*    in   cfg_we            cfg_index, cfg_data
//
// One word per cycle while the output is not stalled. The divider and sqrt
// pipelines each resolve one bit per stage.
// arst_n clears valid bits and loads register defaults.
// A stalled output word freezes the whole pipe; nothing is dropped or repeated.
module range_remap_with_curve_unit
	import rrc_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((DATA_WIDTH+7)/8)*8-1:0]   s_tdata,   // [W-1:0] sample_value
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [((DATA_WIDTH+7)/8)*8-1:0]   m_tdata,   // [W-1:0] mapped_value
	output logic [1:0]                        m_tuser,   // [0] saturated, [1] domain_error
	input  logic                              cfg_we,
	input  logic [CFG_IDX_W-1:0]              cfg_index,
	input  logic [DATA_WIDTH-1:0]             cfg_data
);

	localparam int W   = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int TDW = ((W+7)/8)*8;
	localparam int NB  = W + F;
	localparam int SQ  = (W + F) / 2;
	localparam int NW  = 2 * SQ;
	localparam int PW  = 2 * W;
	localparam int P3W = 2 * W + 1;

	localparam logic signed [W-1:0]   ONE_Q  = W'(1) << F;
	localparam logic signed [W-1:0]   MAX_Q  = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0]   MIN_Q  = {1'b1, {(W-1){1'b0}}};
	localparam logic [NB-1:0]         LIM_NB = NB'(1) << (W-1);
	localparam logic [PW-F-1:0]       MAX_PF = (PW-F)'(MAX_Q);
	localparam logic [PW-F-1:0]       LIM_PF = (PW-F)'(1) << (W-1);
	localparam logic [P3W-F-1:0]      LIM3   = (P3W-F)'(1) << (W+1);
	localparam logic [SQ+W-1:0]       MAX_RZ = (SQ+W)'(MAX_Q);

	// configuration registers
	logic signed [W-1:0] in_low_q, in_high_q, out_low_q, out_high_q;
	curve_t              curve_q;
	logic                clamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_low_q   <= '0;
			in_high_q  <= ONE_Q;
			out_low_q  <= '0;
			out_high_q <= ONE_Q;
			curve_q    <= CURVE_LINEAR;
			clamp_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INPUT_LOW:    in_low_q   <= cfg_data;
				REG_INPUT_HIGH:   in_high_q  <= cfg_data;
				REG_OUTPUT_LOW:   out_low_q  <= cfg_data;
				REG_OUTPUT_HIGH:  out_high_q <= cfg_data;
				REG_CURVE_MODE:   curve_q    <= curve_t'(cfg_data[1:0]);
				REG_CLAMP_ENABLE: clamp_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// s1: offset and span magnitudes
	logic signed [W:0] diff_c, range_c;
	logic [W-1:0]      num_s1, den_s1;
	logic              neg_s1, zero_s1, v_s1;

	assign diff_c  = $signed({s_tdata[W-1], s_tdata[W-1:0]}) - $signed({in_low_q[W-1], in_low_q});
	assign range_c = $signed({in_high_q[W-1], in_high_q}) - $signed({in_low_q[W-1], in_low_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1  <= diff_c[W] ? W'(-diff_c) : diff_c[W-1:0];
			den_s1  <= range_c[W] ? W'(-range_c) : range_c[W-1:0];
			neg_s1  <= diff_c[W] ^ range_c[W];
			zero_s1 <= (range_c == '0);
		end
	end

	// restoring divider, one quotient bit per stage
	logic [NB-1:0] div_nq_s  [1:NB];
	logic [W-1:0]  div_rem_s [1:NB];
	logic [W-1:0]  div_den_s [1:NB];
	logic          div_neg_s [1:NB];
	logic          div_zero_s[1:NB];
	logic          div_v_s   [1:NB];

	for (genvar k = 1; k <= NB; k++) begin : g_div
		logic [NB-1:0] p_nq;
		logic [W-1:0]  p_rem, p_den;
		logic          p_neg, p_zero, p_v, ge;
		logic [W:0]    cur;

		if (k == 1) begin : g_first
			assign p_nq   = {num_s1, {F{1'b0}}};
			assign p_rem  = '0;
			assign p_den  = den_s1;
			assign p_neg  = neg_s1;
			assign p_zero = zero_s1;
			assign p_v    = v_s1;
		end else begin : g_next
			assign p_nq   = div_nq_s[k-1];
			assign p_rem  = div_rem_s[k-1];
			assign p_den  = div_den_s[k-1];
			assign p_neg  = div_neg_s[k-1];
			assign p_zero = div_zero_s[k-1];
			assign p_v    = div_v_s[k-1];
		end

		assign cur = {p_rem, p_nq[NB-1]};
		assign ge  = cur >= {1'b0, p_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k] <= 1'b0;
			end else if (adv) begin
				div_v_s[k] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_nq_s[k]   <= {p_nq[NB-2:0], ge};
				div_rem_s[k]  <= ge ? W'(cur - {1'b0, p_den}) : cur[W-1:0];
				div_den_s[k]  <= p_den;
				div_neg_s[k]  <= p_neg;
				div_zero_s[k] <= p_zero;
			end
		end
	end

	// s2: saturate quotient, clamp
	logic [NB-1:0]       q_c;
	logic signed [W-1:0] t_c;
	logic                tsat_c;
	logic signed [W-1:0] t_s2;
	logic                sat_s2, v_s2;

	assign q_c = div_nq_s[NB];

	always_comb begin
		tsat_c = 1'b0;
		if (div_zero_s[NB]) begin
			t_c = '0;
		end else if (div_neg_s[NB]) begin
			if (q_c > LIM_NB) begin
				t_c    = MIN_Q;
				tsat_c = 1'b1;
			end else begin
				t_c = -$signed(q_c[W-1:0]);
			end
		end else begin
			if (q_c > LIM_NB - NB'(1)) begin
				t_c    = MAX_Q;
				tsat_c = 1'b1;
			end else begin
				t_c = $signed(q_c[W-1:0]);
			end
		end
		if (clamp_q) begin
			if (t_c < 0) begin
				t_c = '0;
			end else if (t_c > ONE_Q) begin
				t_c = ONE_Q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= div_v_s[NB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2   <= t_c;
			sat_s2 <= tsat_c;
		end
	end

	logic mul_mode, smooth_mode;
	assign smooth_mode = (curve_q == CURVE_SMOOTH);
	assign mul_mode    = smooth_mode || (curve_q == CURVE_SQUARE);

	// s3: t*t and (3 - 2t)
	logic signed [W+2:0] k_c;
	logic [W-1:0]        tmag_c;
	logic [PW-1:0]       sqp_s3;
	logic signed [W-1:0] k_s3, t_s3;
	logic                sat_s3, v_s3;

	assign tmag_c = t_s2[W-1] ? W'(-t_s2) : t_s2;
	assign k_c    = (W+3)'(3 * (2 ** F)) - ($signed({{3{t_s2[W-1]}}, t_s2}) <<< 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqp_s3 <= tmag_c * tmag_c;
			t_s3   <= t_s2;
			if (k_c > $signed((W+3)'(MAX_Q))) begin
				k_s3   <= MAX_Q;
				sat_s3 <= sat_s2 || smooth_mode;
			end else if (k_c < $signed({{3{1'b1}}, MIN_Q})) begin
				k_s3   <= MIN_Q;
				sat_s3 <= sat_s2 || smooth_mode;
			end else begin
				k_s3   <= k_c[W-1:0];
				sat_s3 <= sat_s2;
			end
		end
	end

	// s4: scale and saturate t*t
	logic [PW-F-1:0]     sqsh_c;
	logic signed [W-1:0] sq_s4, k_s4, t_s4;
	logic                sat_s4, v_s4;

	assign sqsh_c = sqp_s3[PW-1:F];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s4 <= k_s3;
			t_s4 <= t_s3;
			if (sqsh_c > MAX_PF) begin
				sq_s4  <= MAX_Q;
				sat_s4 <= sat_s3 || mul_mode;
			end else begin
				sq_s4  <= sqsh_c[W-1:0];
				sat_s4 <= sat_s3;
			end
		end
	end

	// s5: t^2 * (3 - 2t)
	logic [W-1:0]        kmag_c;
	logic [PW-1:0]       p2_s5;
	logic                neg2_s5, sat_s5, v_s5;
	logic signed [W-1:0] sq_s5, t_s5;

	assign kmag_c = k_s4[W-1] ? W'(-k_s4) : k_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p2_s5   <= sq_s4[W-1:0] * kmag_c;
			neg2_s5 <= k_s4[W-1];
			sat_s5  <= sat_s4;
			sq_s5   <= sq_s4;
			t_s5    <= t_s4;
		end
	end

	// s6: smoothstep saturation, curve value for the multiply curves, t otherwise
	logic [PW-F-1:0]     sm_c;
	logic signed [W-1:0] sv_c;
	logic                svsat_c;
	logic signed [W-1:0] cv_s6, t_s6;
	logic                sat_s6, v_s6;

	assign sm_c = p2_s5[PW-1:F];

	always_comb begin
		svsat_c = 1'b0;
		if (neg2_s5) begin
			if (sm_c > LIM_PF) begin
				sv_c    = MIN_Q;
				svsat_c = 1'b1;
			end else begin
				sv_c = -$signed(sm_c[W-1:0]);
			end
		end else if (sm_c > MAX_PF) begin
			sv_c    = MAX_Q;
			svsat_c = 1'b1;
		end else begin
			sv_c = $signed(sm_c[W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s6 <= t_s5;
			unique case (curve_q)
				CURVE_SMOOTH: begin
					cv_s6  <= sv_c;
					sat_s6 <= sat_s5 || svsat_c;
				end
				CURVE_SQUARE: begin
					cv_s6  <= sq_s5;
					sat_s6 <= sat_s5;
				end
				default: begin
					cv_s6  <= t_s5;
					sat_s6 <= sat_s5;
				end
			endcase
		end
	end

	// square root, one root bit per stage
	logic [NW-1:0]       sr_n_s    [1:SQ];
	logic [SQ:0]         sr_rem_s  [1:SQ];
	logic [SQ-1:0]       sr_root_s [1:SQ];
	logic signed [W-1:0] sr_cv_s   [1:SQ];
	logic                sr_tneg_s [1:SQ];
	logic                sr_sat_s  [1:SQ];
	logic                sr_v_s    [1:SQ];

	for (genvar k = 1; k <= SQ; k++) begin : g_sqrt
		logic [NW-1:0]       p_n;
		logic [SQ:0]         p_rem;
		logic [SQ-1:0]       p_root;
		logic signed [W-1:0] p_cv;
		logic                p_tneg, p_sat, p_v, ge;
		logic [SQ+2:0]       cur, trial;

		if (k == 1) begin : g_first
			assign p_n    = t_s6[W-1] ? '0 : NW'({t_s6[W-2:0], {F{1'b0}}});
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_cv   = cv_s6;
			assign p_tneg = t_s6[W-1];
			assign p_sat  = sat_s6;
			assign p_v    = v_s6;
		end else begin : g_next
			assign p_n    = sr_n_s[k-1];
			assign p_rem  = sr_rem_s[k-1];
			assign p_root = sr_root_s[k-1];
			assign p_cv   = sr_cv_s[k-1];
			assign p_tneg = sr_tneg_s[k-1];
			assign p_sat  = sr_sat_s[k-1];
			assign p_v    = sr_v_s[k-1];
		end

		assign cur   = {p_rem, p_n[NW-1:NW-2]};
		assign trial = (SQ+3)'({p_root, 2'b01});
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sr_v_s[k] <= 1'b0;
			end else if (adv) begin
				sr_v_s[k] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sr_n_s[k]    <= {p_n[NW-3:0], 2'b00};
				sr_rem_s[k]  <= ge ? (SQ+1)'(cur - trial) : cur[SQ:0];
				sr_root_s[k] <= {p_root[SQ-2:0], ge};
				sr_cv_s[k]   <= p_cv;
				sr_tneg_s[k] <= p_tneg;
				sr_sat_s[k]  <= p_sat;
			end
		end
	end

	// s7: select curve result
	logic [SQ+W-1:0]     rz_c;
	logic signed [W-1:0] y_s7;
	logic                sat_s7, dom_s7, v_s7;

	assign rz_c = (SQ+W)'(sr_root_s[SQ]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= sr_v_s[SQ];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_s7 <= sr_sat_s[SQ];
			dom_s7 <= 1'b0;
			if (curve_q != CURVE_SQRT) begin
				y_s7 <= sr_cv_s[SQ];
			end else if (sr_tneg_s[SQ]) begin
				y_s7   <= '0;
				dom_s7 <= 1'b1;
			end else if (rz_c > MAX_RZ) begin
				y_s7   <= MAX_Q;
				sat_s7 <= 1'b1;
			end else begin
				y_s7 <= rz_c[W-1:0];
			end
		end
	end

	// s8: y * (output_high - output_low)
	logic signed [W:0] span_c;
	logic [W:0]        smag_c;
	logic [W-1:0]      ymag_c;
	logic [P3W-1:0]    p3_s8;
	logic              neg3_s8, sat_s8, dom_s8, v_s8;

	assign span_c = $signed({out_high_q[W-1], out_high_q}) - $signed({out_low_q[W-1], out_low_q});
	assign smag_c = span_c[W] ? (W+1)'(-span_c) : span_c;
	assign ymag_c = y_s7[W-1] ? W'(-y_s7) : y_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p3_s8   <= ymag_c * smag_c;
			neg3_s8 <= y_s7[W-1] ^ span_c[W];
			sat_s8  <= sat_s7;
			dom_s8  <= dom_s7;
		end
	end

	// s9: saturate to two extra bits, add output_low
	logic [P3W-F-1:0]    sh3_c;
	logic signed [W+1:0] o_c;
	logic                osat_c;
	logic signed [W+2:0] sum_s9;
	logic                sat_s9, dom_s9, v_s9;

	assign sh3_c = p3_s8[P3W-1:F];

	always_comb begin
		osat_c = 1'b0;
		if (neg3_s8) begin
			if (sh3_c > LIM3) begin
				o_c    = {2'b11, MIN_Q} <<< 2;
				osat_c = 1'b1;
			end else begin
				o_c = -$signed(sh3_c[W+1:0]);
			end
		end else if (sh3_c > LIM3 - (P3W-F)'(1)) begin
			o_c    = {1'b0, {(W+1){1'b1}}};
			osat_c = 1'b1;
		end else begin
			o_c = $signed(sh3_c[W+1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s9 <= $signed({o_c[W+1], o_c}) + $signed({{3{out_low_q[W-1]}}, out_low_q});
			sat_s9 <= sat_s8 || osat_c;
			dom_s9 <= dom_s8;
		end
	end

	// output register
	logic signed [W-1:0] res_q;
	logic                rsat_q, rdom_q, rv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (adv) begin
			rv_q <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rdom_q <= dom_s9;
			if (sum_s9 > $signed((W+3)'(MAX_Q))) begin
				res_q  <= MAX_Q;
				rsat_q <= 1'b1;
			end else if (sum_s9 < $signed({{3{1'b1}}, MIN_Q})) begin
				res_q  <= MIN_Q;
				rsat_q <= 1'b1;
			end else begin
				res_q  <= sum_s9[W-1:0];
				rsat_q <= sat_s9;
			end
		end
	end

	assign m_tvalid = rv_q;
	assign m_tdata  = TDW'({1'b0, res_q}) & {{(TDW-W){1'b0}}, {W{1'b1}}};
	assign m_tuser  = {rdom_q, rsat_q};

	a_dom_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> curve_q == CURVE_SQRT)
		else $error("domain error outside sqrt curve");

	a_dom_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[W-1:0] == out_low_q)
		else $error("domain error word not at output_low");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && clamp_q |-> t_s2 >= 0 && t_s2 <= ONE_Q)
		else $error("clamped position out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s1) && $stable(v_s9))
		else $error("pipeline moved during stall");

endmodule
